[sv/rbst_pkg.sv]
`default_nettype none
// shared constants, types and arithmetic steps of the ray box slab test
package rbst_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int TLIM_W    = 31;
    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 2 * NUM_AXES;
    localparam int CFG_IDX_W = 3;

    // quotient bits retired per divide stage
    localparam int QBITS   = 2;
    localparam int DIV_STG = COORD_W / QBITS;

    localparam int STG_P0   = 0;
    localparam int STG_P1   = 1;
    localparam int STG_DIV0 = 2;
    localparam int STG_SAT  = STG_DIV0 + DIV_STG;
    localparam int STG_ORD  = STG_SAT + 1;
    localparam int STG_RED  = STG_ORD + 1;
    localparam int STG_FIN  = STG_RED + 1;
    localparam int STG_OUT  = STG_FIN + 1;
    localparam int NUM_STG  = STG_OUT + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

    localparam logic [COORD_W-1:0] SAT_NEG_MAG = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] quo;
        logic [COORD_W-1:0] nlow;
        logic               neg;
        logic               ovf;
    } t_div_lane;

    // restoring division, QBITS quotient bits
    function automatic t_div_lane div_step(input t_div_lane s, input logic [COORD_W-1:0] ud);
        t_div_lane          o;
        logic [COORD_W+1:0] trial;
        o = s;
        for (int b = 0; b < QBITS; b++) begin
            trial = {1'b0, o.rem, o.nlow[COORD_W-1]} - {2'b00, ud};
            if (!trial[COORD_W+1]) begin
                o.rem = trial[COORD_W-1:0];
                o.quo = {o.quo[COORD_W-2:0], 1'b1};
            end else begin
                o.rem = {o.rem[COORD_W-2:0], o.nlow[COORD_W-1]};
                o.quo = {o.quo[COORD_W-2:0], 1'b0};
            end
            o.nlow = {o.nlow[COORD_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // signed result of the quotient, saturated to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_param(input t_div_lane s);
        logic [COORD_W-1:0] mag;
        mag = (s.ovf || (s.quo > SAT_NEG_MAG)) ? SAT_NEG_MAG : s.quo;
        if (s.neg) begin
            return -mag;
        end
        if (s.ovf || s.quo[COORD_W-1]) begin
            return SAT_POS;
        end
        return s.quo;
    endfunction

endpackage
`default_nettype wire

[sv/rbst_box_if.sv]
`default_nettype none
// box channel: one box and its parameter limit per transfer
interface rbst_box_if;
    logic                                valid;
    logic                                ready;
    logic signed [rbst_pkg::COORD_W-1:0] box_min_x;
    logic signed [rbst_pkg::COORD_W-1:0] box_min_y;
    logic signed [rbst_pkg::COORD_W-1:0] box_min_z;
    logic signed [rbst_pkg::COORD_W-1:0] box_max_x;
    logic signed [rbst_pkg::COORD_W-1:0] box_max_y;
    logic signed [rbst_pkg::COORD_W-1:0] box_max_z;
    logic        [rbst_pkg::TLIM_W-1:0]  t_limit;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z,
        output box_max_x, box_max_y, box_max_z, t_limit,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z,
        input  box_max_x, box_max_y, box_max_z, t_limit,
        output ready
    );
endinterface
`default_nettype wire

[sv/rbst_hit_if.sv]
`default_nettype none
// result channel: one hit flag per transfer
interface rbst_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

[sv/ray_box_slab_test_top.sv]
`default_nettype none
// ray against axis-aligned box slab test, signed Q16.16, one box per transfer
// throughput: one box per cycle; six divide lanes of 16 stages, 2 quotient bits each
// a held result stalls only the stages behind it once they are all full
// reset: clears the stage valid bits and sets ray origin and direction to zero
module ray_box_slab_test_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [rbst_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [rbst_pkg::COORD_W-1:0]      i_cfg_data,
    rbst_box_if.sink                         i_box,
    rbst_hit_if.source                       o_res
);

    logic signed [rbst_pkg::COORD_W-1:0] r_origin  [rbst_pkg::NUM_AXES];
    logic signed [rbst_pkg::COORD_W-1:0] r_dir     [rbst_pkg::NUM_AXES];
    logic        [rbst_pkg::COORD_W-1:0] r_dir_mag [rbst_pkg::NUM_AXES];

    logic [rbst_pkg::NUM_STG-1:0] r_vld;
    logic [rbst_pkg::NUM_STG:0]   en;

    logic [rbst_pkg::TLIM_W-1:0] r_tlim  [rbst_pkg::STG_ORD+1];
    logic                        r_pmiss [rbst_pkg::STG_FIN+1];

    logic signed [rbst_pkg::COORD_W-1:0] w_box_min [rbst_pkg::NUM_AXES];
    logic signed [rbst_pkg::COORD_W-1:0] w_box_max [rbst_pkg::NUM_AXES];
    logic                                w_pmiss;

    logic signed [rbst_pkg::COORD_W:0]   r_diff [rbst_pkg::NUM_LANES];
    logic        [rbst_pkg::COORD_W:0]   r_un   [rbst_pkg::NUM_LANES];
    logic                                r_neg  [rbst_pkg::NUM_LANES];

    rbst_pkg::t_div_lane w_div_init [rbst_pkg::NUM_LANES];
    rbst_pkg::t_div_lane r_div      [rbst_pkg::DIV_STG][rbst_pkg::NUM_LANES];

    logic signed [rbst_pkg::COORD_W-1:0] r_t    [rbst_pkg::NUM_LANES];
    logic signed [rbst_pkg::COORD_W-1:0] r_tmin [rbst_pkg::NUM_AXES];
    logic signed [rbst_pkg::COORD_W-1:0] r_tmax [rbst_pkg::NUM_AXES];
    logic signed [rbst_pkg::COORD_W-1:0] w_tlim;
    logic signed [rbst_pkg::COORD_W-1:0] r_n01;
    logic signed [rbst_pkg::COORD_W-1:0] r_n2;
    logic signed [rbst_pkg::COORD_W-1:0] r_f01;
    logic signed [rbst_pkg::COORD_W-1:0] r_f2;
    logic signed [rbst_pkg::COORD_W-1:0] r_near;
    logic signed [rbst_pkg::COORD_W-1:0] r_far;
    logic                                r_hit;

    // ray registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
                r_origin[a] <= '0;
                r_dir[a]    <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbst_pkg::REG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                rbst_pkg::REG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                rbst_pkg::REG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                rbst_pkg::REG_DIR_X:    r_dir[0]    <= i_cfg_data;
                rbst_pkg::REG_DIR_Y:    r_dir[1]    <= i_cfg_data;
                rbst_pkg::REG_DIR_Z:    r_dir[2]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divisor magnitudes
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            r_dir_mag[a] <= r_dir[a][rbst_pkg::COORD_W-1] ? -r_dir[a] : r_dir[a];
        end
    end

    // stage advance, a stage moves when empty or when the next one moves
    always_comb begin
        en[rbst_pkg::NUM_STG] = o_res.ready;
        for (int k = rbst_pkg::NUM_STG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_box.valid;
            end
            for (int k = 1; k < rbst_pkg::NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_box.ready = en[0];
    assign o_res.valid = r_vld[rbst_pkg::STG_OUT];
    assign o_res.hit   = r_hit;

    // stage 0: slab offsets and parallel axis check
    always_comb begin
        w_box_min[0] = i_box.box_min_x;
        w_box_min[1] = i_box.box_min_y;
        w_box_min[2] = i_box.box_min_z;
        w_box_max[0] = i_box.box_max_x;
        w_box_max[1] = i_box.box_max_y;
        w_box_max[2] = i_box.box_max_z;
        w_pmiss = 1'b0;
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            if ((r_dir[a] == '0) &&
                ((r_origin[a] < w_box_min[a]) || (r_origin[a] > w_box_max[a]))) begin
                w_pmiss = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_P0]) begin
            for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
                r_diff[a] <= {w_box_min[a][rbst_pkg::COORD_W-1], w_box_min[a]}
                           - {r_origin[a][rbst_pkg::COORD_W-1], r_origin[a]};
                r_diff[a+rbst_pkg::NUM_AXES] <=
                    {w_box_max[a][rbst_pkg::COORD_W-1], w_box_max[a]}
                  - {r_origin[a][rbst_pkg::COORD_W-1], r_origin[a]};
            end
            r_tlim[0]  <= i_box.t_limit;
            r_pmiss[0] <= w_pmiss;
        end
    end

    // side band travels with the item
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= rbst_pkg::STG_ORD; k++) begin
            if (en[k]) begin
                r_tlim[k] <= r_tlim[k-1];
            end
        end
        for (int k = 1; k <= rbst_pkg::STG_FIN; k++) begin
            if (en[k]) begin
                r_pmiss[k] <= r_pmiss[k-1];
            end
        end
    end

    // stage 1: magnitudes and quotient sign
    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_P1]) begin
            for (int l = 0; l < rbst_pkg::NUM_LANES; l++) begin
                r_un[l]  <= r_diff[l][rbst_pkg::COORD_W] ? -r_diff[l] : r_diff[l];
                r_neg[l] <= r_diff[l][rbst_pkg::COORD_W]
                          ^ r_dir[l % rbst_pkg::NUM_AXES][rbst_pkg::COORD_W-1];
            end
        end
    end

    // divide pipeline, dividend is the magnitude shifted up by the fraction bits
    always_comb begin
        for (int l = 0; l < rbst_pkg::NUM_LANES; l++) begin
            w_div_init[l].rem  = {{(rbst_pkg::COORD_W-rbst_pkg::FRAC_W-1){1'b0}},
                                  r_un[l][rbst_pkg::COORD_W:rbst_pkg::COORD_W-rbst_pkg::FRAC_W]};
            w_div_init[l].quo  = '0;
            w_div_init[l].nlow = {r_un[l][rbst_pkg::COORD_W-rbst_pkg::FRAC_W-1:0],
                                  {rbst_pkg::FRAC_W{1'b0}}};
            w_div_init[l].neg  = r_neg[l];
            // quotient would need more than the coordinate width
            w_div_init[l].ovf  = (w_div_init[l].rem >= r_dir_mag[l % rbst_pkg::NUM_AXES]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < rbst_pkg::NUM_LANES; l++) begin
            if (en[rbst_pkg::STG_DIV0]) begin
                r_div[0][l] <= rbst_pkg::div_step(w_div_init[l],
                                                  r_dir_mag[l % rbst_pkg::NUM_AXES]);
            end
            for (int j = 1; j < rbst_pkg::DIV_STG; j++) begin
                if (en[rbst_pkg::STG_DIV0+j]) begin
                    r_div[j][l] <= rbst_pkg::div_step(r_div[j-1][l],
                                                      r_dir_mag[l % rbst_pkg::NUM_AXES]);
                end
            end
        end
    end

    // saturation and sign
    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_SAT]) begin
            for (int l = 0; l < rbst_pkg::NUM_LANES; l++) begin
                r_t[l] <= rbst_pkg::sat_param(r_div[rbst_pkg::DIV_STG-1][l]);
            end
        end
    end

    // order the two slab parameters, parallel axes are neutral
    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_ORD]) begin
            for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
                if (r_dir[a] == '0) begin
                    r_tmin[a] <= '0;
                    r_tmax[a] <= rbst_pkg::SAT_POS;
                end else if (r_t[a] > r_t[a+rbst_pkg::NUM_AXES]) begin
                    r_tmin[a] <= r_t[a+rbst_pkg::NUM_AXES];
                    r_tmax[a] <= r_t[a];
                end else begin
                    r_tmin[a] <= r_t[a];
                    r_tmax[a] <= r_t[a+rbst_pkg::NUM_AXES];
                end
            end
        end
    end

    assign w_tlim = {{(rbst_pkg::COORD_W-rbst_pkg::TLIM_W){1'b0}}, r_tlim[rbst_pkg::STG_ORD]};

    // near and far reduction
    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_RED]) begin
            r_n01 <= (r_tmin[0] > r_tmin[1]) ? r_tmin[0] : r_tmin[1];
            r_n2  <= (r_tmin[2] > 0) ? r_tmin[2] : '0;
            r_f01 <= (r_tmax[0] < r_tmax[1]) ? r_tmax[0] : r_tmax[1];
            r_f2  <= (r_tmax[2] < w_tlim) ? r_tmax[2] : w_tlim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_FIN]) begin
            r_near <= (r_n01 > r_n2) ? r_n01 : r_n2;
            r_far  <= (r_f01 < r_f2) ? r_f01 : r_f2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[rbst_pkg::STG_OUT]) begin
            r_hit <= !r_pmiss[rbst_pkg::STG_FIN] && (r_far >= r_near);
        end
    end

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_box.valid && i_box.ready && !(o_res.valid && o_res.ready))
        |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("pipeline occupancy did not grow on an unmatched input transfer");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> ((&r_vld) && !o_res.ready))
        else $error("input blocked while the pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("stage valid bits not cleared by reset");

endmodule
`default_nettype wire
